// File: src/sakfk_pkg.sv
// Package: shared types and constants of the six-axis forward kinematics block.
package sakfk_pkg;

    localparam int LEN_W   = 30;
    localparam int ROT_W   = 32;
    localparam int NUM_REG = 6;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_D1 = 3'd0;
    localparam logic [IDX_W-1:0] REG_A2 = 3'd1;
    localparam logic [IDX_W-1:0] REG_A3 = 3'd2;
    localparam logic [IDX_W-1:0] REG_D4 = 3'd3;
    localparam logic [IDX_W-1:0] REG_D5 = 3'd4;
    localparam logic [IDX_W-1:0] REG_D6 = 3'd5;

    localparam logic signed [LEN_W-1:0] RST_D1 = 30'sd43671991;
    localparam logic signed [LEN_W-1:0] RST_A2 = -30'sd114089268;
    localparam logic signed [LEN_W-1:0] RST_A3 = -30'sd105257467;
    localparam logic signed [LEN_W-1:0] RST_D4 = 30'sd35846024;
    localparam logic signed [LEN_W-1:0] RST_D5 = 30'sd26732580;
    localparam logic signed [LEN_W-1:0] RST_D6 = 30'sd26709270;

    localparam logic [31:0] TURN_PER_RAD = 32'd683565276;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

    typedef logic [31:0] coef_t;

    // Taylor coefficients of the quarter sine, Q.30
    function automatic coef_t sin_coef(input logic [2:0] k);
        coef_t c;
        unique case (k)
            3'd0: c = 32'd1686629713;
            3'd1: c = 32'd693598668;
            3'd2: c = 32'd85569306;
            3'd3: c = 32'd5026995;
            3'd4: c = 32'd172272;
            3'd5: c = 32'd3864;
            3'd6: c = 32'd61;
            default: c = 32'd1;
        endcase
        return c;
    endfunction

    // r(a*b) for signed operands of up to 36 bits
    function automatic logic signed [35:0] rmul(input logic signed [35:0] a,
                                                input logic signed [35:0] b);
        logic signed [71:0] p;
        p = a * b + 72'sd536870912;
        return p[65:30];
    endfunction

    typedef struct packed {
        logic signed [LEN_W-1:0] d1;
        logic signed [LEN_W-1:0] a2;
        logic signed [LEN_W-1:0] a3;
        logic signed [LEN_W-1:0] d4;
        logic signed [LEN_W-1:0] d5;
        logic signed [LEN_W-1:0] d6;
    } links_t;

endpackage

// File: src/sakfk_if.sv
// Interface: valid/ready channel carrying one item of type payload_t.
interface sakfk_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/sakfk_sincos.sv
// Sine and cosine of one Q.28 angle: a pipeline of phase, polynomial and quadrant stages.
module sakfk_sincos (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic signed [33:0]  angle,
    output logic signed [33:0]  sin_out,
    output logic signed [33:0]  cos_out
);
    import sakfk_pkg::*;

    // Stage count: 1 phase, 1 fraction split, 1 square, 8 Horner (last applies x),
    // 1 result, 1 quadrant = 13
    localparam int HS = 8;

    logic [31:0] ph_reg;
    logic signed [67:0] prod;
    logic [29:0] f_next;

    assign prod = angle * $signed({36'd0, TURN_PER_RAD});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph_reg <= prod[59:28];
        end
    end

    assign f_next = ph_reg[29:0];

    // two evaluation lanes: x = f and x = 2^30 - f
    logic [30:0] x_reg  [2];
    logic [1:0]  q_reg;
    logic [30:0] x2_reg [2];
    logic [30:0] xp_reg [HS][2];
    logic [31:0] p_reg  [HS][2];
    logic [1:0]  qp_reg [HS];
    logic [30:0] s_reg  [2];
    logic [1:0]  qs_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= {1'b0, f_next};
            x_reg[1] <= 31'h40000000 - {1'b0, f_next};
            q_reg    <= ph_reg[31:30];
        end
    end

    logic [1:0] q1_reg;
    logic [30:0] x1_reg [2];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 2; l++)
            begin
                x2_reg[l] <= 31'((({31'd0, x_reg[l]} * {31'd0, x_reg[l]})
                             + 62'd536870912) >> 30);
                x1_reg[l] <= x_reg[l];
            end
            q1_reg <= q_reg;
        end
    end

    logic [30:0] x2p_reg [HS][2];
    for (genvar s = 0; s < HS; s++)
    begin : g_horner
        logic [31:0] pin  [2];
        logic [30:0] xin  [2];
        logic [30:0] x2in [2];
        logic [1:0]  qin;
        if (s == 0)
        begin : g_first
            assign pin[0] = sin_coef(3'd7);
            assign pin[1] = sin_coef(3'd7);
            assign xin = x1_reg;
            assign x2in = x2_reg;
            assign qin = q1_reg;
        end
        else
        begin : g_rest
            assign pin = p_reg[s-1];
            assign xin = xp_reg[s-1];
            assign x2in = x2p_reg[s-1];
            assign qin = qp_reg[s-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < 2; l++)
                begin
                    logic [63:0] t;
                    logic [31:0] ck;
                    ck = sin_coef(3'(6 - s));
                    t = ({32'd0, pin[l]} * {33'd0, x2in[l]} + 64'd536870912) >> 30;
                    if (s == HS - 1)
                    begin
                        // final step: p*x
                        t = ({32'd0, pin[l]} * {33'd0, xin[l]} + 64'd536870912) >> 30;
                        p_reg[s][l] <= (t > 64'd1073741824) ? 32'h40000000 : t[31:0];
                    end
                    else
                    begin
                        p_reg[s][l] <= (t > {32'd0, ck}) ? 32'd0 : ck - t[31:0];
                    end
                    xp_reg[s][l] <= xin[l];
                    x2p_reg[s][l] <= x2in[l];
                end
                qp_reg[s] <= qin;
            end
        end
    end

    // the loop above covers C6..C0 in stages 0..6; stage 7 applies x
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg[0] <= p_reg[HS-1][0][30:0];
            s_reg[1] <= p_reg[HS-1][1][30:0];
            qs_reg   <= qp_reg[HS-1];
        end
    end

    logic signed [33:0] sf, cf;
    assign sf = $signed({3'd0, s_reg[0]});
    assign cf = $signed({3'd0, s_reg[1]});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unique case (qs_reg)
                2'd0:    begin sin_out <= sf;  cos_out <= cf;  end
                2'd1:    begin sin_out <= cf;  cos_out <= -sf; end
                2'd2:    begin sin_out <= -sf; cos_out <= -cf; end
                default: begin sin_out <= -cf; cos_out <= sf;  end
            endcase
        end
    end

    logic unused_rst;
    assign unused_rst = rst_n;
endmodule

// File: src/six_axis_forward_kinematics.sv
// Top level: six-axis forward kinematics pipeline with configuration registers.
//
// Usage:
//   in_ch  carries one joint vector per item (six signed Q4.(DATA_WIDTH-4)
//          radian angles). out_ch carries the flange pose: nine Q2.30
//          rotation entries and three Q2.28 positions, saturated.
//   cfg_we/cfg_idx/cfg_data write the six link lengths; an unknown index
//   is ignored. Write only while the pipeline is empty.
// Throughput: one item per cycle while out_ch is not stalled. From accept to
//   out_ch valid an item passes the 13-deep sine/cosine pipeline (phase,
//   fraction split, square, seven Horner steps and the final multiply,
//   result, quadrant) and then five product stages.
// Reset: valid bits clear and the link registers take their nominal values.
// Stall: when an item waits at out_ch and out_ch.ready is low, the whole
//   pipeline holds and in_ch.ready drops with it; bubbles inside are held
//   too, and no item is lost or repeated.
module six_axis_forward_kinematics #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sakfk_pkg::IDX_W-1:0]       cfg_idx,
    input  logic [sakfk_pkg::LEN_W-1:0]       cfg_data,
    sakfk_if.sink                             in_ch,
    sakfk_if.source                           out_ch
);
    import sakfk_pkg::*;

    localparam int SC_LAT = 13;
    localparam int LAT    = SC_LAT + 5;

    links_t lnk_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lnk_reg <= '{RST_D1, RST_A2, RST_A3, RST_D4, RST_D5, RST_D6};
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_D1: lnk_reg.d1 <= cfg_data;
                REG_A2: lnk_reg.a2 <= cfg_data;
                REG_A3: lnk_reg.a3 <= cfg_data;
                REG_D4: lnk_reg.d4 <= cfg_data;
                REG_D5: lnk_reg.d5 <= cfg_data;
                REG_D6: lnk_reg.d6 <= cfg_data;
                default: ;
            endcase
        end
    end

    // valid chain; advance as a whole whenever the output slot is free
    logic [LAT-1:0] vld_reg;
    logic en;
    assign en = !vld_reg[LAT-1] || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_ch.valid};
        end
    end

    // bring each angle to Q.28
    function automatic logic signed [33:0] to_q28(input logic [DATA_WIDTH-1:0] a);
        logic signed [DATA_WIDTH+1:0] e;
        e = $signed({{2{a[DATA_WIDTH-1]}}, a});
        if (DATA_WIDTH >= 32)
            return 34'(e >>> (DATA_WIDTH - 32));
        else
            return 34'(e) <<< (32 - DATA_WIDTH);
    endfunction

    logic signed [33:0] ang [7];
    assign ang[0] = to_q28(in_ch.data[6*DATA_WIDTH-1 -: DATA_WIDTH]);
    assign ang[1] = to_q28(in_ch.data[5*DATA_WIDTH-1 -: DATA_WIDTH]);
    assign ang[2] = to_q28(in_ch.data[4*DATA_WIDTH-1 -: DATA_WIDTH]);
    assign ang[3] = to_q28(in_ch.data[3*DATA_WIDTH-1 -: DATA_WIDTH]);
    assign ang[4] = to_q28(in_ch.data[2*DATA_WIDTH-1 -: DATA_WIDTH]);
    assign ang[5] = to_q28(in_ch.data[DATA_WIDTH-1:0]);
    assign ang[6] = ang[1] + ang[2];

    logic signed [33:0] sn [7];
    logic signed [33:0] cs [7];
    for (genvar j = 0; j < 7; j++)
    begin : g_sc
        sakfk_sincos u_sc (
            .clk(clk), .rst_n(rst_n), .en(en), .angle(ang[j]),
            .sin_out(sn[j]), .cos_out(cs[j])
        );
    end

    // Index map: 0 q1, 1 q2, 3 q4, 4 q5, 5 q6, 6 q2+q3
    typedef logic signed [35:0] w_t;
    function automatic w_t wx(input logic signed [33:0] v);
        return 36'(v);
    endfunction

    // stage A: first-level products
    w_t c23c4_reg, s23c4_reg, s23s5_reg, c23s5_reg, s23c5_reg, c23c5_reg;
    w_t c23s4_reg, s4c5_reg, s4s5_reg, s23s4_reg;
    w_t c1s23_reg, s1s23_reg, c1c23_reg, s1c23_reg, c1c2_reg, s1c2_reg;
    w_t c1_a, s1_a, c4_a, c5_a, s5_a, c6_a, s6_a, s2_a, s23_a, c23_a;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c23c4_reg <= rmul(wx(cs[6]), wx(cs[3]));
            s23c4_reg <= rmul(wx(sn[6]), wx(cs[3]));
            s23s5_reg <= rmul(wx(sn[6]), wx(sn[4]));
            c23s5_reg <= rmul(wx(cs[6]), wx(sn[4]));
            s23c5_reg <= rmul(wx(sn[6]), wx(cs[4]));
            c23c5_reg <= rmul(wx(cs[6]), wx(cs[4]));
            c23s4_reg <= rmul(wx(cs[6]), wx(sn[3]));
            s4c5_reg  <= rmul(wx(sn[3]), wx(cs[4]));
            s4s5_reg  <= rmul(wx(sn[3]), wx(sn[4]));
            s23s4_reg <= rmul(wx(sn[6]), wx(sn[3]));
            c1s23_reg <= rmul(wx(cs[0]), wx(sn[6]));
            s1s23_reg <= rmul(wx(sn[0]), wx(sn[6]));
            c1c23_reg <= rmul(wx(cs[0]), wx(cs[6]));
            s1c23_reg <= rmul(wx(sn[0]), wx(cs[6]));
            c1c2_reg  <= rmul(wx(cs[0]), wx(cs[1]));
            s1c2_reg  <= rmul(wx(sn[0]), wx(cs[1]));
            c1_a <= wx(cs[0]); s1_a <= wx(sn[0]); c4_a <= wx(cs[3]);
            c5_a <= wx(cs[4]); s5_a <= wx(sn[4]); c6_a <= wx(cs[5]);
            s6_a <= wx(sn[5]); s2_a <= wx(sn[1]);
            s23_a <= wx(sn[6]); c23_a <= wx(cs[6]);
        end
    end

    // stage B: pp, qq, zz and wrist-free rot z row pieces
    w_t pp_b, qq_b, zz_b, s4c5_b, s4s5_b, u3_b, v3_b, r8_b;
    w_t c1_b, s1_b, c4_b, c6_b, s6_b;
    w_t c1s23_b, s1s23_b, c1c23_b, s1c23_b, c1c2_b, s1c2_b, s2_b, s23_b, c23_b;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_b <= rmul(c23c4_reg, c5_a) - s23s5_reg;
            qq_b <= c23s4_reg;
            zz_b <= rmul(c23c4_reg, s5_a) + s23c5_reg;
            s4c5_b <= s4c5_reg; s4s5_b <= s4s5_reg;
            u3_b <= -(rmul(s23c4_reg, c5_a) + c23s5_reg);
            v3_b <= s23s4_reg;
            r8_b <= c23c5_reg - rmul(s23c4_reg, s5_a);
            c1_b <= c1_a; s1_b <= s1_a; c4_b <= c4_a; c6_b <= c6_a; s6_b <= s6_a;
            c1s23_b <= c1s23_reg; s1s23_b <= s1s23_reg; c1c23_b <= c1c23_reg;
            s1c23_b <= s1c23_reg; c1c2_b <= c1c2_reg; s1c2_b <= s1c2_reg;
            s2_b <= s2_a; s23_b <= s23_a; c23_b <= c23_a;
        end
    end

    // stage C: u, v per row and rot column z
    w_t u_c [3], v_c [3], rz_c [3];
    w_t c6_c, s6_c, c1_c, s1_c;
    w_t c1s23_c, s1s23_c, c1c23_c, s1c23_c, c1c2_c, s1c2_c, s2_c, s23_c, c23_c;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_c[0] <= rmul(c1_b, pp_b) + rmul(s1_b, s4c5_b);
            v_c[0] <= -rmul(c1_b, qq_b) + rmul(s1_b, c4_b);
            rz_c[0] <= rmul(c1_b, zz_b) + rmul(s1_b, s4s5_b);
            u_c[1] <= rmul(s1_b, pp_b) - rmul(c1_b, s4c5_b);
            v_c[1] <= -rmul(s1_b, qq_b) - rmul(c1_b, c4_b);
            rz_c[1] <= rmul(s1_b, zz_b) - rmul(c1_b, s4s5_b);
            u_c[2] <= u3_b; v_c[2] <= v3_b; rz_c[2] <= r8_b;
            c6_c <= c6_b; s6_c <= s6_b; c1_c <= c1_b; s1_c <= s1_b;
            c1s23_c <= c1s23_b; s1s23_c <= s1s23_b; c1c23_c <= c1c23_b;
            s1c23_c <= s1c23_b; c1c2_c <= c1c2_b; s1c2_c <= s1c2_b;
            s2_c <= s2_b; s23_c <= s23_b; c23_c <= c23_b;
        end
    end

    function automatic w_t sat_rot(input w_t v);
        if (v > 36'sd1073741824) return 36'sd1073741824;
        if (v < -36'sd1073741824) return -36'sd1073741824;
        return v;
    endfunction

    // stage D: saturated rotation and link products
    w_t rot_d [9];
    w_t lp_d [3][4];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                rot_d[3*r]   <= sat_rot(rmul(c6_c, u_c[r]) - rmul(s6_c, v_c[r]));
                rot_d[3*r+1] <= sat_rot(-rmul(s6_c, u_c[r]) - rmul(c6_c, v_c[r]));
                rot_d[3*r+2] <= sat_rot(rz_c[r]);
            end
            lp_d[0][0] <= rmul(wx(34'(lnk_reg.d5)), c1s23_c);
            lp_d[0][1] <= rmul(wx(34'(lnk_reg.d4)), s1_c);
            lp_d[0][2] <= rmul(wx(34'(lnk_reg.a3)), c1c23_c);
            lp_d[0][3] <= rmul(wx(34'(lnk_reg.a2)), c1c2_c);
            lp_d[1][0] <= rmul(wx(34'(lnk_reg.d5)), s1s23_c);
            lp_d[1][1] <= -rmul(wx(34'(lnk_reg.d4)), c1_c);
            lp_d[1][2] <= rmul(wx(34'(lnk_reg.a3)), s1c23_c);
            lp_d[1][3] <= rmul(wx(34'(lnk_reg.a2)), s1c2_c);
            lp_d[2][0] <= rmul(wx(34'(lnk_reg.d5)), c23_c);
            lp_d[2][1] <= wx(34'(lnk_reg.d1));
            lp_d[2][2] <= -rmul(wx(34'(lnk_reg.a3)), s23_c);
            lp_d[2][3] <= -rmul(wx(34'(lnk_reg.a2)), s2_c);
        end
    end

    // stage E: positions and output register
    logic signed [ROT_W-1:0] rot_o [9];
    logic signed [LEN_W-1:0] pos_o [3];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                logic signed [39:0] sum;
                sum = 40'(rmul(wx(34'(lnk_reg.d6)), rot_d[3*r+2])) + 40'(lp_d[r][0])
                    + 40'(lp_d[r][1]) + 40'(lp_d[r][2]) + 40'(lp_d[r][3]);
                if (sum > 40'sd536870911)
                    pos_o[r] <= 30'sh1FFFFFFF;
                else if (sum < -40'sd536870912)
                    pos_o[r] <= 30'sh20000000;
                else
                    pos_o[r] <= sum[LEN_W-1:0];
            end
            for (int i = 0; i < 9; i++)
            begin
                rot_o[i] <= rot_d[i][ROT_W-1:0];
            end
        end
    end

    assign out_ch.valid = vld_reg[LAT-1];
    assign out_ch.data = {rot_o[0], rot_o[1], rot_o[2], rot_o[3], rot_o[4], rot_o[5],
                          rot_o[6], rot_o[7], rot_o[8], pos_o[0], pos_o[1], pos_o[2]};
endmodule

// File: src/sakfk_checker.sv
// Checker: port-level properties of the kinematics block, and its bind.
module sakfk_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);
    // a stalled output holds its valid
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output item dropped while stalled");

    // input is taken whenever the output slot is free
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // input stalls only behind a stalled output
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without cause");
endmodule

bind six_axis_forward_kinematics sakfk_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready)
);

// File: bench/six_axis_forward_kinematics_test.sv
// Testbench: random and directed joint vectors checked against a fixed-point pose predictor.
`timescale 1ns / 100ps

module six_axis_forward_kinematics_test;
    import sakfk_pkg::*;

    // Payload of one joint vector: six signed Q4.28 angles, q1 at the top.
    typedef struct packed {
        logic signed [31:0] q1;
        logic signed [31:0] q2;
        logic signed [31:0] q3;
        logic signed [31:0] q4;
        logic signed [31:0] q5;
        logic signed [31:0] q6;
    } joints_t;

    // Payload of one pose: row-major Q2.30 rotation, then Q2.28 position.
    typedef struct packed {
        logic signed [ROT_W-1:0] rxx;
        logic signed [ROT_W-1:0] rxy;
        logic signed [ROT_W-1:0] rxz;
        logic signed [ROT_W-1:0] ryx;
        logic signed [ROT_W-1:0] ryy;
        logic signed [ROT_W-1:0] ryz;
        logic signed [ROT_W-1:0] rzx;
        logic signed [ROT_W-1:0] rzy;
        logic signed [ROT_W-1:0] rzz;
        logic signed [LEN_W-1:0] px;
        logic signed [LEN_W-1:0] py;
        logic signed [LEN_W-1:0] pz;
    } pose_t;

    // Register indexes the block does not decode.
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam longint LEN_MAX   = 64'sd536870911;
    localparam longint LEN_MIN   = -64'sd536870912;
    localparam longint UNIT_Q30  = 64'sd1073741824;
    localparam longint HALF_Q30  = 64'sd536870912;
    localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
    localparam logic signed [31:0] PI_Q28      = 32'sd843314857;

    // Pose predictor with its own copy of the link lengths and a queue of
    // poses still owed by the pipeline.
    class pose_scoreboard;
        longint links [NUM_REG];
        pose_t  owed_poses [$];
        int     mismatches;
        longint unsigned taylor [8];

        function new();
            taylor = '{64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995,
                       64'd172272, 64'd3864, 64'd61, 64'd1};
            links = '{64'sd43671991, -64'sd114089268, -64'sd105257467,
                      64'sd35846024, 64'sd26732580, 64'sd26709270};
            mismatches = 0;
        endfunction

        function void set_link(logic [IDX_W-1:0] idx, logic [LEN_W-1:0] val);
            if (idx < NUM_REG)
                links[idx] = longint'($signed(val));
        endfunction

        function longint rnd_mul(longint a, longint b);
            return (a * b + HALF_Q30) >>> 30;
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        // Odd Taylor polynomial of the quarter sine, Horner form, Q.30.
        function longint quarter_sin(longint unsigned x);
            longint unsigned x2, p, t;
            x2 = (x * x + 64'd536870912) >> 30;
            p = taylor[7];
            for (int k = 6; k >= 0; k--)
            begin
                t = (p * x2 + 64'd536870912) >> 30;
                p = (t > taylor[k]) ? 64'd0 : taylor[k] - t;
            end
            p = (p * x + 64'd536870912) >> 30;
            if (p > 64'd1073741824)
                p = 64'd1073741824;
            return longint'(p);
        endfunction

        function void sin_cos(longint ang, output longint s, output longint c);
            longint unsigned prod, ph, f;
            longint sf, cf;
            prod = longint'(ang * longint'(TURN_PER_RAD));
            ph = (prod >> 28) & 64'hFFFF_FFFF;
            f = ph & 64'h3FFF_FFFF;
            sf = quarter_sin(f);
            cf = quarter_sin(64'd1073741824 - f);
            case (ph[31:30])
                2'd0:    begin s = sf;  c = cf;  end
                2'd1:    begin s = cf;  c = -sf; end
                2'd2:    begin s = -sf; c = -cf; end
                default: begin s = -cf; c = sf;  end
            endcase
        endfunction

        // Note an accepted joint vector: work out its pose and queue it.
        function void note_joints(joints_t j);
            longint s1, c1, s2, c2, s4, c4, s5, c5, s6, c6, s23, c23;
            longint pp, qq, zz, s4c5, s4s5, u, v;
            longint r [9];
            longint p [3];
            pose_t e;
            sin_cos(longint'(j.q1), s1, c1);
            sin_cos(longint'(j.q2), s2, c2);
            sin_cos(longint'(j.q4), s4, c4);
            sin_cos(longint'(j.q5), s5, c5);
            sin_cos(longint'(j.q6), s6, c6);
            sin_cos(longint'(j.q2) + longint'(j.q3), s23, c23);

            pp = rnd_mul(rnd_mul(c23, c4), c5) - rnd_mul(s23, s5);
            qq = rnd_mul(c23, s4);
            zz = rnd_mul(rnd_mul(c23, c4), s5) + rnd_mul(s23, c5);
            s4c5 = rnd_mul(s4, c5);
            s4s5 = rnd_mul(s4, s5);

            u = rnd_mul(c1, pp) + rnd_mul(s1, s4c5);
            v = -rnd_mul(c1, qq) + rnd_mul(s1, c4);
            r[0] = rnd_mul(c6, u) - rnd_mul(s6, v);
            r[1] = -rnd_mul(s6, u) - rnd_mul(c6, v);
            r[2] = rnd_mul(c1, zz) + rnd_mul(s1, s4s5);

            u = rnd_mul(s1, pp) - rnd_mul(c1, s4c5);
            v = -rnd_mul(s1, qq) - rnd_mul(c1, c4);
            r[3] = rnd_mul(c6, u) - rnd_mul(s6, v);
            r[4] = -rnd_mul(s6, u) - rnd_mul(c6, v);
            r[5] = rnd_mul(s1, zz) - rnd_mul(c1, s4s5);

            u = -(rnd_mul(rnd_mul(s23, c4), c5) + rnd_mul(c23, s5));
            v = rnd_mul(s23, s4);
            r[6] = rnd_mul(c6, u) - rnd_mul(s6, v);
            r[7] = -rnd_mul(s6, u) - rnd_mul(c6, v);
            r[8] = rnd_mul(c23, c5) - rnd_mul(rnd_mul(s23, c4), s5);

            for (int i = 0; i < 9; i++)
                r[i] = clamp(r[i], -UNIT_Q30, UNIT_Q30);

            p[0] = rnd_mul(links[REG_D6], r[2]) + rnd_mul(links[REG_D5], rnd_mul(c1, s23))
                 + rnd_mul(links[REG_D4], s1) + rnd_mul(links[REG_A3], rnd_mul(c1, c23))
                 + rnd_mul(links[REG_A2], rnd_mul(c1, c2));
            p[1] = rnd_mul(links[REG_D6], r[5]) + rnd_mul(links[REG_D5], rnd_mul(s1, s23))
                 - rnd_mul(links[REG_D4], c1) + rnd_mul(links[REG_A3], rnd_mul(s1, c23))
                 + rnd_mul(links[REG_A2], rnd_mul(s1, c2));
            p[2] = rnd_mul(links[REG_D6], r[8]) + rnd_mul(links[REG_D5], c23)
                 + links[REG_D1] - rnd_mul(links[REG_A3], s23)
                 - rnd_mul(links[REG_A2], s2);

            e.rxx = r[0][31:0]; e.rxy = r[1][31:0]; e.rxz = r[2][31:0];
            e.ryx = r[3][31:0]; e.ryy = r[4][31:0]; e.ryz = r[5][31:0];
            e.rzx = r[6][31:0]; e.rzy = r[7][31:0]; e.rzz = r[8][31:0];
            e.px = LEN_W'(clamp(p[0], LEN_MIN, LEN_MAX));
            e.py = LEN_W'(clamp(p[1], LEN_MIN, LEN_MAX));
            e.pz = LEN_W'(clamp(p[2], LEN_MIN, LEN_MAX));
            owed_poses.insert(owed_poses.size(), e);
        endfunction

        function void unpack_pose(pose_t d, output longint f [12]);
            f = '{d.rxx, d.rxy, d.rxz, d.ryx, d.ryy, d.ryz, d.rzx, d.rzy, d.rzz,
                  d.px, d.py, d.pz};
        endfunction

        // Check a pose leaving the block against the oldest one owed.
        function void check_pose(pose_t got);
            string  tags [12];
            longint want_f [12];
            longint got_f [12];
            pose_t  want;
            tags = '{"rot_xx", "rot_xy", "rot_xz", "rot_yx", "rot_yy", "rot_yz",
                     "rot_zx", "rot_zy", "rot_zz", "pos_x", "pos_y", "pos_z"};
            if (owed_poses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pose item at %0t", $realtime);
                return;
            end
            want = owed_poses.pop_front();
            unpack_pose(want, want_f);
            unpack_pose(got, got_f);
            for (int i = 0; i < 12; i++)
                if (want_f[i] != got_f[i])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%s: expected %0d, got %0d at %0t",
                                 tags[i], want_f[i], got_f[i], $realtime);
                end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [IDX_W-1:0]     cfg_idx;
    logic [LEN_W-1:0]     cfg_data;

    sakfk_if #(.payload_t(joints_t)) joint_ch ();
    sakfk_if #(.payload_t(pose_t))   pose_ch ();

    pose_scoreboard board;
    int  joints_sent;
    bit  hold_off;     // long receiver hold-off, driven by its own process
    bit  no_idle;      // stretch with both sides at full rate
    int  pose_wait;

    six_axis_forward_kinematics #(.DATA_WIDTH(32)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .in_ch    (joint_ch.sink),
        .out_ch   (pose_ch.source)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Hard limit on the run: far beyond the slowest correct run.
    initial
    begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: check each accepted pose, then draw the wait before the next.
    // A single assignment to ready per edge keeps the handshake race free.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pose_ch.valid && pose_ch.ready)
            begin
                board.check_pose(pose_ch.data);
                pose_wait = no_idle ? 0 : $urandom_range(0, 6);
            end
            if (hold_off)
                pose_ch.ready <= 1'b0;
            else if (pose_wait > 0)
            begin
                pose_ch.ready <= 1'b0;
                pose_wait--;
            end
            else
                pose_ch.ready <= 1'b1;
        end
    end

    // Hold the receiver off for a long stretch while joint vectors keep coming,
    // so the pipeline fills and back-pressures its input.
    initial
    begin
        hold_off = 1'b0;
        wait (joints_sent == 300);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (120) @(posedge clk);
        hold_off = 1'b0;
    end

    // Offer one joint vector after a random gap and wait until it is taken.
    // Valid stays high straight into the next item when the gap is zero.
    task automatic send_joints(joints_t j);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            joint_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        joint_ch.valid <= 1'b1;
        joint_ch.data  <= j;
        do
            @(posedge clk);
        while (!joint_ch.ready);
        board.note_joints(j);
        joints_sent++;
    endtask

    task automatic send_all_same(logic signed [31:0] a);
        joints_t j;
        j = '{a, a, a, a, a, a};
        send_joints(j);
    endtask

    // Mostly angles within half a turn either side, the rest full range.
    task automatic send_random(int count);
        joints_t j;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 3) == 0)
                j = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            else
            begin
                j.q1 = $signed($urandom_range(0, 2 * PI_Q28)) - PI_Q28;
                j.q2 = $signed($urandom_range(0, 2 * PI_Q28)) - PI_Q28;
                j.q3 = $signed($urandom_range(0, 2 * PI_Q28)) - PI_Q28;
                j.q4 = $signed($urandom_range(0, 2 * PI_Q28)) - PI_Q28;
                j.q5 = $signed($urandom_range(0, 2 * PI_Q28)) - PI_Q28;
                j.q6 = $signed($urandom_range(0, 2 * PI_Q28)) - PI_Q28;
            end
            no_idle = (n % 100) >= 80;
            send_joints(j);
        end
        no_idle = 1'b0;
    endtask

    // Drop valid and wait until every owed pose has come back.
    task automatic drain;
        joint_ch.valid <= 1'b0;
        while (board.owed_poses.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_link(logic [IDX_W-1:0] idx, logic [LEN_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        board.set_link(idx, val);
    endtask

    task automatic write_all_links(logic [LEN_W-1:0] d1, logic [LEN_W-1:0] a2,
                                   logic [LEN_W-1:0] a3, logic [LEN_W-1:0] d4,
                                   logic [LEN_W-1:0] d5, logic [LEN_W-1:0] d6);
        write_link(REG_D1, d1);
        write_link(REG_A2, a2);
        write_link(REG_A3, a3);
        write_link(REG_D4, d4);
        write_link(REG_D5, d5);
        write_link(REG_D6, d6);
    endtask

    initial
    begin
        joints_t j;
        board          = new();
        joints_sent    = 0;
        no_idle        = 1'b0;
        pose_wait      = 0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = REG_D1;
        cfg_data       = '0;
        joint_ch.valid = 1'b0;
        joint_ch.data  = '0;
        pose_ch.ready  = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the nominal link lengths: zero, quadrant edges,
        // field extremes and angles wrapping past a full turn.
        send_all_same(32'sd0);
        send_all_same(HALF_PI_Q28);
        send_all_same(PI_Q28);
        send_all_same(-HALF_PI_Q28);
        send_all_same(-PI_Q28);
        send_all_same(32'sh7FFF_FFFF);
        send_all_same(32'sh8000_0000);
        send_all_same(32'sd1);
        send_all_same(-32'sd1);
        send_all_same(32'sh5555_5555);
        send_all_same(32'shAAAA_AAAA);
        send_all_same(4 * PI_Q28 + 32'sd1000);
        j = '{32'sd0, HALF_PI_Q28, HALF_PI_Q28, 32'sd0, 32'sd0, 32'sd0};
        send_joints(j);
        j = '{HALF_PI_Q28, -HALF_PI_Q28, PI_Q28, HALF_PI_Q28, -HALF_PI_Q28, PI_Q28};
        send_joints(j);
        j = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
              32'sh8000_0000, 32'sh8000_0000};
        send_joints(j);
        send_random(180);
        drain();

        // Largest link lengths drive the position into saturation.
        write_all_links(LEN_W'(LEN_MAX), LEN_W'(LEN_MAX), LEN_W'(LEN_MAX),
                        LEN_W'(LEN_MAX), LEN_W'(LEN_MAX), LEN_W'(LEN_MAX));
        send_all_same(32'sd0);
        send_all_same(PI_Q28);
        send_random(180);
        drain();

        write_all_links(LEN_W'(LEN_MIN), LEN_W'(LEN_MIN), LEN_W'(LEN_MIN),
                        LEN_W'(LEN_MIN), LEN_W'(LEN_MIN), LEN_W'(LEN_MIN));
        send_all_same(32'sd0);
        send_all_same(-HALF_PI_Q28);
        send_random(180);
        drain();

        // Random lengths, then writes to undecoded indexes must change nothing.
        write_all_links(LEN_W'($urandom), LEN_W'($urandom), LEN_W'($urandom),
                        LEN_W'($urandom), LEN_W'($urandom), LEN_W'($urandom));
        write_link(REG_SPARE_LO, LEN_W'($urandom));
        write_link(REG_SPARE_HI, LEN_W'($urandom));
        send_random(180);
        drain();

        write_all_links(RST_D1, RST_A2, RST_A3, RST_D4, RST_D5, RST_D6);
        send_random(180);
        drain();

        if (board.mismatches == 0 && board.owed_poses.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
